/* hw/rtl/rwcp_pkg.sv */
`default_nettype none
package rwcp_pkg;

    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned FMT_BYTES    = 16;
    localparam int unsigned HEAD_BYTES   = 8;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic KIND_PCM    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_HEAD,
        PH_BODY,
        PH_PAD,
        PH_IGNORE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TOO_SHORT,
        ST_BAD_MAGIC,
        ST_NO_FMT,
        ST_NO_DATA
    } status_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  pcm_byte;
        logic        chunk_start;
        logic [2:0]  parse_status;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic        is_last;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] val;
        begin
            unique case (idx)
                4'd0:    val = 8'h52;
                4'd1:    val = 8'h49;
                4'd2:    val = 8'h46;
                4'd3:    val = 8'h46;
                4'd8:    val = 8'h57;
                4'd9:    val = 8'h41;
                4'd10:   val = 8'h56;
                4'd11:   val = 8'h45;
                default: val = 8'h00;
            endcase
            return val;
        end
    endfunction

    function automatic logic magic_checked(input logic [3:0] idx);
        begin
            return (idx < 4'd4) || ((idx >= 4'd8) && (idx < 4'(HEADER_BYTES)));
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/rwcp_if.sv */
`default_nettype none
interface rwcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface rwcp_result_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  pcm_byte;
    logic        chunk_start;
    logic [2:0]  parse_status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic        is_last;

    modport source (
        output valid, output item_kind, output pcm_byte, output chunk_start,
        output parse_status, output format_tag, output channel_count,
        output sample_rate, output byte_rate, output block_align,
        output sample_bits, output is_last, input ready
    );
    modport sink (
        input valid, input item_kind, input pcm_byte, input chunk_start,
        input parse_status, input format_tag, input channel_count,
        input sample_rate, input byte_rate, input block_align,
        input sample_bits, input is_last, output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/riff_wave_chunk_parser.sv */
// Each byte's results are registered in a result queue and leave it in order.
// Throughput: one byte per cycle while the queue holds at most two items; each byte
// is parsed by counters and compares. A final byte inside a data chunk yields two
// results, a data item and then a status item, drained through the four-entry queue.
// Reset (rst_n low, asynchronous) clears the parse state, the format fields and the queue;
// the final byte of each file returns the parse state and format fields to reset values.
`default_nettype none
module riff_wave_chunk_parser
    import rwcp_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    rwcp_byte_if.sink            file_stream,
    rwcp_result_if.source        result_stream
);

    phase_t             phase_reg, phase_next, phase_proc;
    logic [31:0]        pos_reg, pos_next, pos_proc, pos_inc;
    logic [31:0]        tag_reg, tag_next;
    logic [31:0]        len_reg, len_next, len_full;
    logic               bad_reg, bad_next, bad_proc;
    logic               fmt_seen_reg, fmt_seen_next, fmt_seen_proc;
    logic               data_seen_reg, data_seen_next, data_seen_proc;
    logic [127:0]       latched_reg, latched_next, latched_proc;
    logic [7:0]         shadow_reg [FMT_BYTES];
    logic               shadow_we;

    result_t            queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               accept, pop, eof;
    logic [7:0]         b;
    logic               data_push, status_push;
    result_t            data_item, status_item, first_item;
    status_t            status;
    logic               body_last, is_fmt, is_data;

    assign b      = file_stream.in_byte;
    assign eof    = file_stream.end_of_file;
    assign accept = file_stream.valid && file_stream.ready;
    assign pop    = result_stream.valid && result_stream.ready;

    assign pos_inc   = pos_reg + 32'd1;
    assign len_full  = {b, len_reg[23:0]};
    assign body_last = (pos_inc == len_reg);
    assign is_fmt    = (tag_reg == TAG_FMT);
    assign is_data   = (tag_reg == TAG_DATA);

    assign file_stream.ready = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));

    // Datapath: magic check, chunk head capture, fmt capture, data emission
    always_comb
    begin
        bad_proc       = bad_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        fmt_seen_proc  = fmt_seen_reg;
        data_seen_proc = data_seen_reg;
        latched_proc   = latched_reg;
        shadow_we      = 1'b0;
        data_push      = 1'b0;
        data_item      = '0;
        data_item.item_kind   = KIND_PCM;
        data_item.pcm_byte    = b;
        data_item.chunk_start = (pos_reg == 32'd0);
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (magic_checked(pos_reg[3:0]) && (b != magic_byte(pos_reg[3:0])))
                    begin
                        bad_proc = 1'b1;
                    end
                end
                PH_HEAD:
                begin
                    if (pos_reg[2])
                    begin
                        len_next[8*pos_reg[1:0] +: 8] = b;
                    end
                    else
                    begin
                        tag_next[8*pos_reg[1:0] +: 8] = b;
                    end
                    if ((pos_reg[2:0] == 3'(HEAD_BYTES - 1)) && is_data)
                    begin
                        data_seen_proc = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (is_fmt && (pos_reg < 32'(FMT_BYTES)))
                    begin
                        shadow_we = 1'b1;
                        if ((pos_reg[3:0] == 4'(FMT_BYTES - 1)) &&
                            (len_reg >= 32'(FMT_BYTES)))
                        begin
                            fmt_seen_proc = 1'b1;
                            latched_proc  = {b, shadow_reg[14], shadow_reg[13],
                                             shadow_reg[12], shadow_reg[11], shadow_reg[10],
                                             shadow_reg[9], shadow_reg[8], shadow_reg[7],
                                             shadow_reg[6], shadow_reg[5], shadow_reg[4],
                                             shadow_reg[3], shadow_reg[2], shadow_reg[1],
                                             shadow_reg[0]};
                        end
                    end
                    data_push = is_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Next phase and position
    always_comb
    begin
        phase_proc = phase_reg;
        pos_proc   = pos_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg[3:0] == 4'(HEADER_BYTES - 1))
                    begin
                        pos_proc   = '0;
                        phase_proc = bad_proc ? PH_IGNORE : PH_HEAD;
                    end
                    else
                    begin
                        pos_proc = pos_inc;
                    end
                end
                PH_HEAD:
                begin
                    if (pos_reg[2:0] == 3'(HEAD_BYTES - 1))
                    begin
                        pos_proc = '0;
                        if (len_full != 32'd0)
                        begin
                            phase_proc = PH_BODY;
                        end
                    end
                    else
                    begin
                        pos_proc = pos_inc;
                    end
                end
                PH_BODY:
                begin
                    if (body_last)
                    begin
                        pos_proc   = '0;
                        phase_proc = len_reg[0] ? PH_PAD : PH_HEAD;
                    end
                    else
                    begin
                        pos_proc = pos_inc;
                    end
                end
                PH_PAD:
                begin
                    pos_proc   = '0;
                    phase_proc = PH_HEAD;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Status item and end-of-file return to the reset state
    always_comb
    begin
        status_push = accept && eof;
        priority if (phase_proc == PH_HEADER) status = ST_TOO_SHORT;
        else if (bad_proc)                    status = ST_BAD_MAGIC;
        else if (!fmt_seen_proc)              status = ST_NO_FMT;
        else if (!data_seen_proc)             status = ST_NO_DATA;
        else                                  status = ST_OK;

        status_item               = '0;
        status_item.item_kind     = KIND_STATUS;
        status_item.parse_status  = status;
        status_item.format_tag    = latched_proc[15:0];
        status_item.channel_count = latched_proc[31:16];
        status_item.sample_rate   = latched_proc[63:32];
        status_item.byte_rate     = latched_proc[95:64];
        status_item.block_align   = latched_proc[111:96];
        status_item.sample_bits   = latched_proc[127:112];
        status_item.is_last       = 1'b1;

        first_item = data_push ? data_item : status_item;

        if (status_push)
        begin
            phase_next     = PH_HEADER;
            pos_next       = '0;
            bad_next       = 1'b0;
            fmt_seen_next  = 1'b0;
            data_seen_next = 1'b0;
            latched_next   = '0;
        end
        else
        begin
            phase_next     = phase_proc;
            pos_next       = pos_proc;
            bad_next       = bad_proc;
            fmt_seen_next  = fmt_seen_proc;
            data_seen_next = data_seen_proc;
            latched_next   = latched_proc;
        end

        wr_ptr_next = wr_ptr_reg + PTR_W'(data_push) + PTR_W'(status_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(data_push) + CNT_W'(status_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            bad_reg       <= 1'b0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            latched_reg   <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            bad_reg       <= bad_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            latched_reg   <= latched_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        len_reg <= len_next;
        if (shadow_we)
        begin
            shadow_reg[pos_reg[3:0]] <= b;
        end
        if (data_push || status_push)
        begin
            queue_reg[wr_ptr_reg] <= first_item;
        end
        if (data_push && status_push)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= status_item;
        end
    end

    assign result_stream.valid         = (count_reg != '0);
    assign result_stream.item_kind     = queue_reg[rd_ptr_reg].item_kind;
    assign result_stream.pcm_byte      = queue_reg[rd_ptr_reg].pcm_byte;
    assign result_stream.chunk_start   = queue_reg[rd_ptr_reg].chunk_start;
    assign result_stream.parse_status  = queue_reg[rd_ptr_reg].parse_status;
    assign result_stream.format_tag    = queue_reg[rd_ptr_reg].format_tag;
    assign result_stream.channel_count = queue_reg[rd_ptr_reg].channel_count;
    assign result_stream.sample_rate   = queue_reg[rd_ptr_reg].sample_rate;
    assign result_stream.byte_rate     = queue_reg[rd_ptr_reg].byte_rate;
    assign result_stream.block_align   = queue_reg[rd_ptr_reg].block_align;
    assign result_stream.sample_bits   = queue_reg[rd_ptr_reg].sample_bits;
    assign result_stream.is_last       = queue_reg[rd_ptr_reg].is_last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_eof_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eof) |=> (phase_reg == PH_HEADER) && (pos_reg == 32'd0) && !fmt_seen_reg)
        else $error("parser did not rewind after final byte");

    a_body_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (pos_reg < len_reg))
        else $error("body position past chunk length");

    a_head_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEAD) |-> (pos_reg < 32'(HEAD_BYTES)))
        else $error("chunk head position out of range");
`endif

endmodule
`default_nettype wire

/* test/rwcp_checker.sv */
`timescale 1ns / 1ps
module rwcp_checker
    import rwcp_pkg::*;
(
    input  wire    clk,
    input  wire    rst_n,
    rwcp_byte_if   file_stream,
    rwcp_result_if result_stream,
    output int     errors,
    output int     outstanding
);

    localparam logic [31:0] RIFF_ID = 32'h4646_4952;
    localparam logic [31:0] WAVE_ID = 32'h4556_4157;

    phase_t      phase;
    logic [31:0] fpos;
    logic [31:0] tag;
    logic [31:0] len;
    logic        magic_bad;
    logic        fmt_ok;
    logic        data_ok;
    logic [63:0] shadow [2];
    logic [63:0] latched [2];
    result_t     pending_items [$];

    task automatic clear_parse();
        phase     = PH_HEADER;
        fpos      = '0;
        tag       = '0;
        len       = '0;
        magic_bad = 1'b0;
        fmt_ok    = 1'b0;
        data_ok   = 1'b0;
        shadow[0] = '0;
        shadow[1] = '0;
        latched[0] = '0;
        latched[1] = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eof);
        result_t r;
        status_t st;
        case (phase)
            PH_HEADER:
            begin
                if (fpos < 4)
                begin
                    if (b != RIFF_ID[8*fpos[1:0] +: 8])
                        magic_bad = 1'b1;
                end
                else if (fpos >= 8 && fpos < HEADER_BYTES)
                begin
                    if (b != WAVE_ID[8*fpos[1:0] +: 8])
                        magic_bad = 1'b1;
                end
                fpos++;
                if (fpos >= HEADER_BYTES)
                begin
                    fpos  = '0;
                    phase = magic_bad ? PH_IGNORE : PH_HEAD;
                end
            end
            PH_HEAD:
            begin
                if (fpos == 0)
                begin
                    tag = '0;
                    len = '0;
                end
                if (fpos < 4)
                    tag[8*fpos[1:0] +: 8] = b;
                else
                    len[8*fpos[1:0] +: 8] = b;
                fpos++;
                if (fpos >= HEAD_BYTES)
                begin
                    fpos = '0;
                    if (tag == TAG_DATA)
                        data_ok = 1'b1;
                    if (len != 0)
                        phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (tag == TAG_FMT && fpos < FMT_BYTES)
                begin
                    if (fpos == 0)
                    begin
                        shadow[0] = '0;
                        shadow[1] = '0;
                    end
                    shadow[fpos[3]][8*fpos[2:0] +: 8] = b;
                    if (fpos == FMT_BYTES - 1 && len >= FMT_BYTES)
                    begin
                        latched[0] = shadow[0];
                        latched[1] = shadow[1];
                        fmt_ok     = 1'b1;
                    end
                end
                if (tag == TAG_DATA)
                begin
                    r             = '0;
                    r.item_kind   = KIND_PCM;
                    r.pcm_byte    = b;
                    r.chunk_start = (fpos == 0);
                    pending_items.push_back(r);
                end
                fpos++;
                if (fpos >= len)
                begin
                    fpos  = '0;
                    phase = len[0] ? PH_PAD : PH_HEAD;
                end
            end
            PH_PAD:
            begin
                phase = PH_HEAD;
                fpos  = '0;
            end
            default:
            begin
            end
        endcase

        if (eof)
        begin
            if (phase == PH_HEADER)
                st = ST_TOO_SHORT;
            else if (magic_bad)
                st = ST_BAD_MAGIC;
            else if (!fmt_ok)
                st = ST_NO_FMT;
            else if (!data_ok)
                st = ST_NO_DATA;
            else
                st = ST_OK;
            r               = '0;
            r.item_kind     = KIND_STATUS;
            r.parse_status  = st;
            r.format_tag    = latched[0][15:0];
            r.channel_count = latched[0][31:16];
            r.sample_rate   = latched[0][63:32];
            r.byte_rate     = latched[1][31:0];
            r.block_align   = latched[1][47:32];
            r.sample_bits   = latched[1][63:48];
            r.is_last       = 1'b1;
            pending_items.push_back(r);
            clear_parse();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            clear_parse();
            pending_items.delete();
            errors = 0;
        end
        else
        begin
            if (result_stream.valid && result_stream.ready)
            begin
                if (pending_items.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected transfer: expected none, actual kind %0d byte 0x%0h",
                             $time, result_stream.item_kind, result_stream.pcm_byte);
                end
                else
                begin
                    want = pending_items.pop_front();
                    check_field("item_kind", 32'(want.item_kind),
                                32'(result_stream.item_kind));
                    check_field("pcm_byte", 32'(want.pcm_byte),
                                32'(result_stream.pcm_byte));
                    check_field("chunk_start", 32'(want.chunk_start),
                                32'(result_stream.chunk_start));
                    check_field("parse_status", 32'(want.parse_status),
                                32'(result_stream.parse_status));
                    check_field("format_tag", 32'(want.format_tag),
                                32'(result_stream.format_tag));
                    check_field("channel_count", 32'(want.channel_count),
                                32'(result_stream.channel_count));
                    check_field("sample_rate", want.sample_rate, result_stream.sample_rate);
                    check_field("byte_rate", want.byte_rate, result_stream.byte_rate);
                    check_field("block_align", 32'(want.block_align),
                                32'(result_stream.block_align));
                    check_field("sample_bits", 32'(want.sample_bits),
                                32'(result_stream.sample_bits));
                    check_field("is_last", 32'(want.is_last),
                                32'(result_stream.is_last));
                end
            end
            if (file_stream.valid && file_stream.ready)
                parse_byte(file_stream.in_byte, file_stream.end_of_file);
        end
        outstanding = pending_items.size();
    end

endmodule

/* test/riff_wave_chunk_parser_tb.sv */
`timescale 1ns / 1ps
module riff_wave_chunk_parser_tb;
    import rwcp_pkg::*;

    localparam logic [31:0] RIFF_ID    = 32'h4646_4952;
    localparam logic [31:0] WAVE_ID    = 32'h4556_4157;
    localparam int          FILE_ITEMS = 550;

    logic       clk;
    logic       rst_n;
    int         errors;
    int         outstanding;
    int         sent;
    bit         src_calm;
    bit         snk_calm;
    logic [7:0] file_q [$];

    rwcp_byte_if   file_stream ();
    rwcp_result_if result_stream ();

    riff_wave_chunk_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .file_stream   (file_stream),
        .result_stream (result_stream)
    );

    rwcp_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .file_stream   (file_stream),
        .result_stream (result_stream),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("[riff_wave_chunk_parser] ERROR");
        $finish;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_q.push_back(w[8*i +: 8]);
    endtask

    task automatic add_chunk(input logic [31:0] tag, input logic [31:0] len,
                             input int body_len);
        add_word(tag);
        add_word(len);
        repeat (body_len) file_q.push_back(8'($urandom));
        if (body_len == len && len[0])
            file_q.push_back(8'($urandom));
    endtask

    task automatic make_file();
        int          pick;
        int          idx;
        int          body;
        logic [31:0] tag;
        logic [31:0] len;
        file_q.delete();
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            repeat ($urandom_range(20, 1)) file_q.push_back(8'($urandom));
            return;
        end
        add_word(RIFF_ID);
        add_word($urandom);
        add_word(WAVE_ID);
        if (pick < 18)
        begin
            idx = $urandom_range(7);
            if (idx >= 4)
                idx += 4;
            file_q[idx] ^= 8'($urandom_range(255, 1));
        end
        repeat ($urandom_range(3, 0))
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                idx = $urandom_range(9);
                if (idx < 2)
                    len = $urandom_range(15, 0);
                else if (idx < 4)
                    len = $urandom_range(21, 17);
                else
                    len = FMT_BYTES;
                add_chunk(TAG_FMT, len, len);
            end
            else if (pick < 80)
            begin
                len = $urandom_range(12, 0);
                add_chunk(TAG_DATA, len, len);
            end
            else
            begin
                len = $urandom_range(6, 0);
                add_chunk($urandom, len, len);
            end
        end
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            idx = $urandom_range(2);
            tag = (idx == 0) ? TAG_FMT : (idx == 1) ? TAG_DATA : 32'($urandom);
            len = $urandom | 32'h100;
            body = $urandom_range(20, 0);
            add_chunk(tag, len, body);
        end
        else if (pick < 35)
        begin
            idx = $urandom_range(file_q.size(), 1);
            while (file_q.size() > idx)
                void'(file_q.pop_back());
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            file_stream.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        file_stream.valid       <= 1'b1;
        file_stream.in_byte     <= b;
        file_stream.end_of_file <= last;
        @(posedge clk);
        while (!file_stream.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
        if ($urandom_range(4) == 0)
            src_calm = !src_calm;
    endtask

    task automatic drain();
        file_stream.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        result_stream.ready = 1'b0;
        snk_calm = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap(snk_calm);
            if (stall > 0)
            begin
                result_stream.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_stream.ready <= 1'b1;
            repeat ($urandom_range(6, 1)) @(posedge clk);
            if ($urandom_range(19) == 0)
                snk_calm = !snk_calm;
        end
    end

    initial
    begin
        rst_n                   = 1'b0;
        file_stream.valid       = 1'b0;
        file_stream.in_byte     = '0;
        file_stream.end_of_file = 1'b0;
        sent                    = 0;
        src_calm                = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        file_q.delete();
        file_q.push_back(8'h52);
        send_file();

        file_q.delete();
        file_q.push_back(8'h52);
        file_q.push_back(8'h49);
        file_q.push_back(8'h46);
        file_q.push_back(8'h58);
        file_q.push_back(8'h00);
        send_file();

        file_q.delete();
        add_word(RIFF_ID);
        add_word(32'hFFFF_FFFF);
        add_word(WAVE_ID);
        add_chunk(TAG_DATA, 0, 0);
        send_file();
        drain();

        while (sent < FILE_ITEMS)
        begin
            make_file();
            send_file();
            if ($urandom_range(7) == 0)
                drain();
        end
        drain();
        repeat (4) @(posedge clk);

        if (errors == 0)
            $display("[riff_wave_chunk_parser] OK");
        else
            $display("[riff_wave_chunk_parser] ERROR");
        $finish;
    end

endmodule

/* riff_wave_chunk_parser.f */
hw/rtl/rwcp_pkg.sv
hw/rtl/rwcp_if.sv
hw/rtl/riff_wave_chunk_parser.sv
test/rwcp_checker.sv
test/riff_wave_chunk_parser_tb.sv
